FILE: hdl/pnca_pkg.sv
// Shared types and constants for the palette nearest color allocator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package pnca_pkg;

   localparam int COMMAND_W   = 2;
   localparam int CHAN_IN_W   = 10;
   localparam int CHAN_W      = 8;
   localparam int WEIGHT_W    = 10;
   localparam int WF_W        = 16;
   localparam int SQ_W        = 16;
   localparam int TERM_W      = 32;
   localparam int DIST_W      = 33;
   localparam int INDEX_W     = 8;
   localparam int FREE_W      = 9;
   localparam int CSR_INDEX_W = 2;

   localparam logic [COMMAND_W-1:0] CMD_FIND     = 2'd0;
   localparam logic [COMMAND_W-1:0] CMD_ALLOC    = 2'd1;
   localparam logic [COMMAND_W-1:0] CMD_FREE_ALL = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_RED_WEIGHT   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GREEN_WEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLUE_WEIGHT  = 2'd2;

   localparam logic [WEIGHT_W-1:0] RED_WEIGHT_RESET   = 10'd299;
   localparam logic [WEIGHT_W-1:0] GREEN_WEIGHT_RESET = 10'd587;
   localparam logic [WEIGHT_W-1:0] BLUE_WEIGHT_RESET  = 10'd114;

   localparam logic [DIST_W-1:0] DIST_NONE = '1;

   typedef struct packed {
      logic [CHAN_W-1:0] r;
      logic [CHAN_W-1:0] g;
      logic [CHAN_W-1:0] b;
   } rgb_type;

   typedef struct packed {
      logic [WEIGHT_W-1:0] r;
      logic [WEIGHT_W-1:0] g;
      logic [WEIGHT_W-1:0] b;
   } weights_type;

   typedef struct packed {
      logic [WF_W-1:0] r;
      logic [WF_W-1:0] g;
      logic [WF_W-1:0] b;
   } wf_type;

   typedef struct packed {
      logic    used;
      rgb_type color;
   } pal_entry_type;

   typedef struct packed {
      logic valid;
      logic used;
   } dist_tag_type;

   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic               no_entry;
      logic               newly_allocated;
      logic [DIST_W-1:0]  best_distance;
      logic [FREE_W-1:0]  free_count;
   } rsp_beat_type;

endpackage

`default_nettype wire

FILE: hdl/pnca_req_if.sv
// Request channel of the palette allocator: valid/ready plus command beat.
// Depends on pnca_pkg for field widths.
`default_nettype none

interface pnca_req_if;
   import pnca_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [COMMAND_W-1:0]        command;
   logic signed [CHAN_IN_W-1:0] red_in;
   logic signed [CHAN_IN_W-1:0] green_in;
   logic signed [CHAN_IN_W-1:0] blue_in;
   logic [DIST_W-1:0]           tolerance;

   modport source (output valid, command, red_in, green_in, blue_in, tolerance,
                   input ready);
   modport sink   (input valid, command, red_in, green_in, blue_in, tolerance,
                   output ready);
endinterface

`default_nettype wire

FILE: hdl/pnca_rsp_if.sv
// Response channel of the palette allocator: valid/ready plus result beat.
// Depends on pnca_pkg for field widths.
`default_nettype none

interface pnca_rsp_if;
   import pnca_pkg::*;

   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] index;
   logic               no_entry;
   logic               newly_allocated;
   logic [DIST_W-1:0]  best_distance;
   logic [FREE_W-1:0]  free_count;

   modport source (output valid, index, no_entry, newly_allocated, best_distance,
                   free_count, input ready);
   modport sink   (input valid, index, no_entry, newly_allocated, best_distance,
                   free_count, output ready);
endinterface

`default_nettype wire

FILE: hdl/pnca_palette_mem.sv
// Palette storage: one write port, one registered read port.
// Each word holds the used flag and the RGB color; depends on pnca_pkg.
`default_nettype none

module pnca_palette_mem #(
   parameter int ENTRIES = 256,
   parameter int ADDR_W  = 8
) (
   input  logic                   clock,
   input  logic                   we,
   input  logic [ADDR_W-1:0]      waddr,
   input  pnca_pkg::pal_entry_type wdata,
   input  logic [ADDR_W-1:0]      raddr,
   output pnca_pkg::pal_entry_type rdata
);
   import pnca_pkg::*;

   pal_entry_type entries_ff [ENTRIES];
   pal_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         entries_ff[waddr] <= wdata;
      end
      rd_data_ff <= entries_ff[raddr];
   end

   assign rdata = rd_data_ff;

endmodule

`default_nettype wire

FILE: hdl/pnca_dist_unit.sv
// Pipelined weighted distance unit, one palette entry per cycle.
// Stages: abs diff, square, times weight*factor, three-term sum. Uses pnca_pkg.
`default_nettype none

module pnca_dist_unit #(
   parameter int ADDR_W = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [ADDR_W-1:0]       in_addr,
   input  pnca_pkg::pal_entry_type in_entry,
   input  pnca_pkg::rgb_type       target,
   input  pnca_pkg::wf_type        wf,
   output pnca_pkg::dist_tag_type  out_tag,
   output logic [ADDR_W-1:0]       out_addr,
   output logic [pnca_pkg::DIST_W-1:0] out_dist
);
   import pnca_pkg::*;

   logic [2:0][CHAN_W-1:0] tgt;
   logic [2:0][CHAN_W-1:0] src;
   logic [2:0][WF_W-1:0]   wfc;

   dist_tag_type tag1_ff, tag1_in, tag2_ff, tag3_ff, tag4_ff;
   logic [ADDR_W-1:0] addr1_ff, addr2_ff, addr3_ff, addr4_ff;
   logic [2:0][CHAN_W-1:0] diff_ff, diff_in;
   logic [2:0][SQ_W-1:0]   sq_ff, sq_in;
   logic [2:0][TERM_W-1:0] term_ff, term_in;
   logic [DIST_W-1:0]      dist_ff, dist_in;

   assign tgt = target;
   assign src = in_entry.color;
   assign wfc = wf;

   always_comb begin
      tag1_in.valid = in_valid;
      tag1_in.used  = in_entry.used;
      for (int c = 0; c < 3; c++) begin
         diff_in[c] = (src[c] >= tgt[c]) ? src[c] - tgt[c] : tgt[c] - src[c];
         sq_in[c]   = {{(SQ_W-CHAN_W){1'b0}}, diff_ff[c]} * {{(SQ_W-CHAN_W){1'b0}}, diff_ff[c]};
         term_in[c] = {{(TERM_W-SQ_W){1'b0}}, sq_ff[c]} * {{(TERM_W-WF_W){1'b0}}, wfc[c]};
      end
      dist_in = {1'b0, term_ff[0]} + {1'b0, term_ff[1]} + {1'b0, term_ff[2]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
         tag4_ff <= '0;
      end else begin
         tag1_ff <= tag1_in;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
         tag4_ff <= tag3_ff;
      end
      addr1_ff <= in_addr;
      addr2_ff <= addr1_ff;
      addr3_ff <= addr2_ff;
      addr4_ff <= addr3_ff;
      diff_ff  <= diff_in;
      sq_ff    <= sq_in;
      term_ff  <= term_in;
      dist_ff  <= dist_in;
   end

   assign out_tag  = tag4_ff;
   assign out_addr = addr4_ff;
   assign out_dist = dist_ff;

endmodule

`default_nettype wire

FILE: hdl/pnca_sequencer.sv
// Sequencer: clearing pass, scan addressing, best/free tracking, allocation
// and the result register. Drives pnca_palette_mem and pnca_dist_unit; uses pnca_pkg.
`default_nettype none

module pnca_sequencer #(
   parameter int ENTRIES = 256,
   parameter int ADDR_W  = 8,
   parameter int CNT_W   = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   pnca_req_if.sink                 req_chan,
   pnca_rsp_if.source               rsp_chan,
   input  pnca_pkg::weights_type    weights,
   output logic                     mem_we,
   output logic [ADDR_W-1:0]        mem_waddr,
   output pnca_pkg::pal_entry_type  mem_wdata,
   output logic [ADDR_W-1:0]        mem_raddr,
   output logic                     issue_valid,
   output logic [ADDR_W-1:0]        issue_addr,
   output pnca_pkg::rgb_type        target,
   output pnca_pkg::wf_type         wf,
   input  pnca_pkg::dist_tag_type   dist_tag,
   input  logic [ADDR_W-1:0]        dist_addr,
   input  logic [pnca_pkg::DIST_W-1:0] dist_value
);
   import pnca_pkg::*;

   localparam int PIPE_DEPTH = 5;
   localparam int DRAIN_W    = $clog2(PIPE_DEPTH);
   localparam int IDX_EXT_W  = (ADDR_W > INDEX_W) ? ADDR_W : INDEX_W;
   localparam int CNT_EXT_W  = (CNT_W > FREE_W) ? CNT_W : FREE_W;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(ENTRIES - 1);
   localparam logic [CNT_W-1:0]  FREE_RESET = CNT_W'(ENTRIES - 2);

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_SETUP, ST_SCAN, ST_DRAIN, ST_FINISH
   } state_type;

   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic                clear_reply_ff, clear_reply_in;
   logic [COMMAND_W-1:0] cmd_ff, cmd_in;
   rgb_type             target_ff, target_in;
   logic [DIST_W-1:0]   tol_ff, tol_in;
   wf_type              wf_ff, wf_in;
   logic                issue_valid_ff, issue_valid_in;
   logic [ADDR_W-1:0]   issue_addr_ff, issue_addr_in;
   logic [DIST_W-1:0]   best_ff, best_in;
   logic [ADDR_W-1:0]   best_idx_ff, best_idx_in;
   logic                found_ff, found_in;
   logic                stop_ff, stop_in;
   logic                free_found_ff, free_found_in;
   logic [ADDR_W-1:0]   free_idx_ff, free_idx_in;
   logic [DRAIN_W-1:0]  drain_ff, drain_in;
   logic [CNT_W-1:0]    unused_ff, unused_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_beat_type        rsp_ff, rsp_in;

   logic                take, better, exact, need_alloc, claim;
   logic [ADDR_W-1:0]   chosen;
   logic [IDX_EXT_W-1:0] chosen_ext;
   logic [CNT_EXT_W-1:0] count_ext;
   logic [CHAN_W-1:0]   max_chan;

   function automatic logic [CHAN_W-1:0] clamp_chan(input logic signed [CHAN_IN_W-1:0] v);
      logic [CHAN_W-1:0] res;
      if (v[CHAN_IN_W-1]) begin
         res = '0;
      end else if (|v[CHAN_IN_W-2:CHAN_W]) begin
         res = '1;
      end else begin
         res = v[CHAN_W-1:0];
      end
      return res;
   endfunction

   function automatic logic [WF_W-1:0] chan_wf(input logic [WEIGHT_W-1:0] w,
                                               input logic [CHAN_W-1:0] m,
                                               input logic [CHAN_W-1:0] t);
      logic [CHAN_W-1:0] gap;
      logic [5:0]        f;
      gap = m - t;
      f   = 6'd32 - {1'b0, gap[CHAN_W-1:3]};
      return {{(WF_W-WEIGHT_W){1'b0}}, w} * {{(WF_W-6){1'b0}}, f};
   endfunction

   always_comb begin
      state_in       = state_ff;
      addr_in        = addr_ff;
      clear_reply_in = clear_reply_ff;
      cmd_in         = cmd_ff;
      target_in      = target_ff;
      tol_in         = tol_ff;
      wf_in          = wf_ff;
      issue_valid_in = 1'b0;
      issue_addr_in  = addr_ff;
      best_in        = best_ff;
      best_idx_in    = best_idx_ff;
      found_in       = found_ff;
      stop_in        = stop_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      drain_in       = drain_ff;
      unused_in      = unused_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_in         = rsp_ff;
      mem_we         = 1'b0;
      mem_waddr      = addr_ff;
      mem_wdata      = '0;
      need_alloc     = 1'b0;
      claim          = 1'b0;
      chosen         = best_idx_ff;
      chosen_ext     = '0;
      count_ext      = '0;

      max_chan = (target_ff.r > target_ff.g) ? target_ff.r : target_ff.g;
      if (target_ff.b > max_chan) begin
         max_chan = target_ff.b;
      end

      take   = dist_tag.valid && !stop_ff && (state_ff == ST_SCAN || state_ff == ST_DRAIN);
      better = take && dist_tag.used && (dist_value < best_ff);
      exact  = better && (dist_value == '0);
      if (better) begin
         best_in     = dist_value;
         best_idx_in = dist_addr;
         found_in    = 1'b1;
         stop_in     = exact;
      end
      if (take && !dist_tag.used && !free_found_ff) begin
         free_found_in = 1'b1;
         free_idx_in   = dist_addr;
      end

      case (state_ff)
         ST_CLEAR: begin
            mem_we               = 1'b1;
            mem_wdata.used       = (addr_ff == '0) || (addr_ff == LAST_ADDR);
            mem_wdata.color      = (addr_ff == LAST_ADDR) ? '1 : '0;
            addr_in              = addr_ff + 1'b1;
            if (addr_ff == LAST_ADDR) begin
               addr_in  = '0;
               state_in = clear_reply_ff ? ST_FINISH : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_chan.valid) begin
               cmd_in      = req_chan.command;
               target_in.r = clamp_chan(req_chan.red_in);
               target_in.g = clamp_chan(req_chan.green_in);
               target_in.b = clamp_chan(req_chan.blue_in);
               tol_in      = req_chan.tolerance;
               if (req_chan.command == CMD_FREE_ALL) begin
                  state_in       = ST_CLEAR;
                  clear_reply_in = 1'b1;
                  addr_in        = '0;
                  unused_in      = FREE_RESET;
               end else begin
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            wf_in.r       = chan_wf(weights.r, max_chan, target_ff.r);
            wf_in.g       = chan_wf(weights.g, max_chan, target_ff.g);
            wf_in.b       = chan_wf(weights.b, max_chan, target_ff.b);
            best_in       = DIST_NONE;
            best_idx_in   = '0;
            found_in      = 1'b0;
            stop_in       = 1'b0;
            free_found_in = 1'b0;
            free_idx_in   = '0;
            addr_in       = ADDR_W'(1);
            state_in      = ST_SCAN;
         end
         ST_SCAN: begin
            issue_valid_in = 1'b1;
            issue_addr_in  = addr_ff;
            addr_in        = addr_ff + 1'b1;
            if (addr_ff == LAST_ADDR || exact) begin
               addr_in  = '0;
               drain_in = DRAIN_W'(PIPE_DEPTH - 1);
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (drain_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               drain_in = drain_ff - 1'b1;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in   = 1'b1;
               clear_reply_in = 1'b0;
               state_in       = ST_IDLE;
               if (cmd_ff == CMD_FREE_ALL) begin
                  count_ext         = CNT_EXT_W'(unused_ff);
                  rsp_in            = '0;
                  rsp_in.free_count = count_ext[FREE_W-1:0];
               end else begin
                  need_alloc = (cmd_ff == CMD_ALLOC) && (!found_ff || best_ff > tol_ff);
                  claim      = need_alloc && free_found_ff;
                  if (claim) begin
                     mem_we          = 1'b1;
                     mem_waddr       = free_idx_ff;
                     mem_wdata.used  = 1'b1;
                     mem_wdata.color = target_ff;
                     chosen          = free_idx_ff;
                     if (unused_ff != '0) begin
                        unused_in = unused_ff - 1'b1;
                     end
                  end
                  chosen_ext             = IDX_EXT_W'(chosen);
                  count_ext              = CNT_EXT_W'(unused_in);
                  rsp_in.index           = (found_ff || claim) ? chosen_ext[INDEX_W-1:0] : '0;
                  rsp_in.no_entry        = !(found_ff || claim);
                  rsp_in.newly_allocated = claim;
                  rsp_in.best_distance   = best_ff;
                  rsp_in.free_count      = count_ext[FREE_W-1:0];
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         addr_ff        <= '0;
         clear_reply_ff <= 1'b0;
         issue_valid_ff <= 1'b0;
         stop_ff        <= 1'b0;
         drain_ff       <= '0;
         unused_ff      <= FREE_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         addr_ff        <= addr_in;
         clear_reply_ff <= clear_reply_in;
         issue_valid_ff <= issue_valid_in;
         stop_ff        <= stop_in;
         drain_ff       <= drain_in;
         unused_ff      <= unused_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      target_ff     <= target_in;
      tol_ff        <= tol_in;
      wf_ff         <= wf_in;
      issue_addr_ff <= issue_addr_in;
      best_ff       <= best_in;
      best_idx_ff   <= best_idx_in;
      found_ff      <= found_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      rsp_ff        <= rsp_in;
   end

   assign mem_raddr      = addr_ff;
   assign issue_valid    = issue_valid_ff;
   assign issue_addr     = issue_addr_ff;
   assign target         = target_ff;
   assign wf             = wf_ff;

   assign req_chan.ready          = (state_ff == ST_IDLE);
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.index          = rsp_ff.index;
   assign rsp_chan.no_entry       = rsp_ff.no_entry;
   assign rsp_chan.newly_allocated = rsp_ff.newly_allocated;
   assign rsp_chan.best_distance  = rsp_ff.best_distance;
   assign rsp_chan.free_count     = rsp_ff.free_count;

endmodule

`default_nettype wire

FILE: hdl/palette_nearest_color_allocator_top.sv
// Top level of the palette nearest color allocator: weight registers and wiring
// of pnca_sequencer, pnca_palette_mem and pnca_dist_unit. Uses pnca_pkg, pnca_*_if.
//
//   channel   dir  handshake            beat
//   req_chan  in   valid/ready          command, red_in, green_in, blue_in, tolerance
//   rsp_chan  out  valid/ready          index, no_entry, newly_allocated,
//                                       best_distance, free_count
//   csr_*     in   write enable only    csr_index, csr_write_data (10 bits)
//
// Find/allocate: entries 1..ENTRIES-1 are scanned through the distance pipeline,
// one entry a cycle, before req_chan.ready rises again; an exact match ends the
// scan early. Free_all: a clearing sweep of the palette before the next ready.
// After reset a clearing pass over all ENTRIES runs before req_chan.ready rises.
// The result register frees the core; a new result waits only while the last one
// is still held by rsp_chan.ready low.
`default_nettype none

module palette_nearest_color_allocator_top #(
   parameter int ENTRIES = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   pnca_req_if.sink                             req_chan,
   pnca_rsp_if.source                           rsp_chan,
   input  logic                                 csr_write_enable,
   input  logic [pnca_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pnca_pkg::WEIGHT_W-1:0]        csr_write_data
);
   import pnca_pkg::*;

   localparam int ADDR_W = $clog2(ENTRIES);
   localparam int CNT_W  = $clog2(ENTRIES - 1);

   weights_type weights_ff, weights_in;

   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   pal_entry_type     mem_wdata;
   logic [ADDR_W-1:0] mem_raddr;
   pal_entry_type     mem_rdata;
   logic              issue_valid;
   logic [ADDR_W-1:0] issue_addr;
   rgb_type           target;
   wf_type            wf;
   dist_tag_type      dist_tag;
   logic [ADDR_W-1:0] dist_addr;
   logic [DIST_W-1:0] dist_value;

   always_comb begin
      weights_in = weights_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_RED_WEIGHT:   weights_in.r = csr_write_data;
            CSR_GREEN_WEIGHT: weights_in.g = csr_write_data;
            CSR_BLUE_WEIGHT:  weights_in.b = csr_write_data;
            default:          weights_in = weights_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weights_ff.r <= RED_WEIGHT_RESET;
         weights_ff.g <= GREEN_WEIGHT_RESET;
         weights_ff.b <= BLUE_WEIGHT_RESET;
      end else begin
         weights_ff <= weights_in;
      end
   end

   pnca_sequencer #(
      .ENTRIES (ENTRIES),
      .ADDR_W  (ADDR_W),
      .CNT_W   (CNT_W)
   ) u_sequencer (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .weights     (weights_ff),
      .mem_we      (mem_we),
      .mem_waddr   (mem_waddr),
      .mem_wdata   (mem_wdata),
      .mem_raddr   (mem_raddr),
      .issue_valid (issue_valid),
      .issue_addr  (issue_addr),
      .target      (target),
      .wf          (wf),
      .dist_tag    (dist_tag),
      .dist_addr   (dist_addr),
      .dist_value  (dist_value)
   );

   pnca_palette_mem #(
      .ENTRIES (ENTRIES),
      .ADDR_W  (ADDR_W)
   ) u_palette_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   pnca_dist_unit #(
      .ADDR_W (ADDR_W)
   ) u_dist_unit (
      .clock    (clock),
      .reset    (reset),
      .in_valid (issue_valid),
      .in_addr  (issue_addr),
      .in_entry (mem_rdata),
      .target   (target),
      .wf       (wf),
      .out_tag  (dist_tag),
      .out_addr (dist_addr),
      .out_dist (dist_value)
   );

endmodule

`default_nettype wire
